// ===== design/tpp_pkg.sv =====
// Shared types and constants for the tracker pattern packer.
package tpp_pkg;

    localparam int CHANNELS = 64;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_MAX = 7'(CHANNELS);

    localparam int NSLOT = 8;

    // Byte slots of one cell, in stream order
    localparam int SLOT_CH   = 0;
    localparam int SLOT_MASK = 1;
    localparam int SLOT_NOTE = 2;
    localparam int SLOT_INST = 3;
    localparam int SLOT_VOL  = 4;
    localparam int SLOT_EFF  = 5;
    localparam int SLOT_DAT  = 6;
    localparam int SLOT_EOR  = 7;

    // Mask bit positions
    localparam int MB_NOTE = 0;
    localparam int MB_INST = 1;
    localparam int MB_VOL  = 2;
    localparam int MB_EFF  = 3;

    localparam logic [7:0] LET_P = 8'h50;
    localparam logic [7:0] LET_V = 8'h56;
    localparam logic [7:0] LET_F = 8'h46;
    localparam logic [7:0] LET_E = 8'h45;
    localparam logic [7:0] LET_A = 8'h41;
    localparam logic [7:0] EFF_UP = 8'(LET_F - LET_A + 8'd1);
    localparam logic [7:0] EFF_DN = 8'(LET_E - LET_A + 8'd1);

    localparam logic [7:0] DAT_BASE  = 8'hE0;
    localparam logic [7:0] NIB_MASK  = 8'h0F;
    localparam logic [7:0] CH_FLAG   = 8'h80;
    localparam logic [8:0] INST_NONE = 9'h1FF;
    localparam logic [4:0] VOL_NONE  = 5'h1F;
    localparam logic [7:0] PORTA_RST = 8'd128;

    typedef struct packed {
        logic [3:0] mask;
        logic       hvld;
        logic [7:0] hnote;
        logic [7:0] porta;
    } t_entry;

    localparam t_entry ENTRY_RST = '{mask: 4'd0, hvld: 1'b0, hnote: 8'd0, porta: PORTA_RST};

    typedef struct packed {
        logic       sop;
        logic [6:0] channel;
        logic       note_present;
        logic [7:0] note;
        logic [8:0] instrument;
        logic [4:0] volume;
        logic [7:0] effect_letter;
        logic [7:0] effect_param;
        logic [7:0] second_letter;
        logic [7:0] second_param;
        logic       eor;
    } t_cell;

    typedef struct packed {
        logic [NSLOT-1:0][7:0] bytes;
        logic [NSLOT-1:0]      pend;
    } t_pack;

endpackage

// ===== design/tracker_pattern_packer_core.sv =====
// A cell is registered on acceptance together with its channel state read, then loaded
// into the output serializer once that is free. Output: one byte per cycle while i_stall
// is low; a cell sends up to 8 bytes, and the next cell loads as its last byte is taken.
// Channel state sits in a 64-entry memory read at acceptance; a write in that cycle forwards.
// Reset (synchronous) clears the per-channel valid bits, so every channel reads its
// reset state at once; start of pattern clears them the same way.
module tracker_pattern_packer_core import tpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_start_of_pattern,
    input  logic [6:0]        i_channel,
    input  logic              i_note_present,
    input  logic [7:0]        i_note,
    input  logic signed [8:0] i_instrument,
    input  logic signed [4:0] i_volume,
    input  logic [7:0]        i_effect_letter,
    input  logic [7:0]        i_effect_param,
    input  logic [7:0]        i_second_letter,
    input  logic [7:0]        i_second_param,
    input  logic              i_end_of_row,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);

    t_entry r_mem [CHANNELS];

    logic [CHANNELS-1:0] r_vbits;
    logic [CHANNELS-1:0] n_vbits;

    logic            r_s1_v;
    t_cell           r_s1;
    logic            r_s1_ok;
    logic [CH_W-1:0] r_s1_addr;

    t_entry r_rd;
    logic   r_rd_vld;
    logic   r_fwd_hit;
    logic   r_fwd_clr;
    t_entry r_fwd;

    logic            in_acc;
    logic            in_ok;
    logic [6:0]      chm1;
    logic [CH_W-1:0] in_addr;
    t_cell           in_cell;
    logic            ser_free;
    logic            s1_fire;
    t_entry          base;
    t_entry          upd;
    t_pack           pk;

    assign chm1    = i_channel - 7'd1;
    assign in_addr = chm1[CH_W-1:0];
    assign in_ok   = (i_channel != 7'd0) && (i_channel <= CH_MAX);

    assign in_cell = '{sop: i_start_of_pattern, channel: i_channel,
                       note_present: i_note_present, note: i_note,
                       instrument: i_instrument, volume: i_volume,
                       effect_letter: i_effect_letter, effect_param: i_effect_param,
                       second_letter: i_second_letter, second_param: i_second_param,
                       eor: i_end_of_row};

    assign s1_fire = r_s1_v && ser_free;
    assign o_stall = r_s1_v && !ser_free;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_fire) begin
            r_s1_v <= 1'b0;
        end
    end

    // capture the cell, the memory read and any write landing in the same cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1      <= in_cell;
            r_s1_ok   <= in_ok;
            r_s1_addr <= in_addr;
            r_rd      <= r_mem[in_addr];
            r_rd_vld  <= r_vbits[in_addr];
            r_fwd_hit <= s1_fire && r_s1_ok && (r_s1_addr == in_addr);
            r_fwd_clr <= s1_fire && r_s1.sop;
            r_fwd     <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_ok) begin
            r_mem[r_s1_addr] <= upd;
        end
    end

    always_comb begin
        n_vbits = r_vbits;
        if (s1_fire) begin
            if (r_s1.sop) begin
                n_vbits = '0;
            end
            if (r_s1_ok) begin
                n_vbits[r_s1_addr] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
        end else begin
            r_vbits <= n_vbits;
        end
    end

    always_comb begin
        if (r_s1.sop) begin
            base = ENTRY_RST;
        end else if (r_fwd_hit) begin
            base = r_fwd;
        end else if (r_fwd_clr || !r_rd_vld) begin
            base = ENTRY_RST;
        end else begin
            base = r_rd;
        end
    end

    tpp_pack u_pack (
        .i_cell (r_s1),
        .i_ok   (r_s1_ok),
        .i_base (base),
        .o_upd  (upd),
        .o_pack (pk)
    );

    tpp_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_fire),
        .i_pack     (pk),
        .o_free     (ser_free),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

`ifndef SYNTHESIS
    a_more_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("cell bytes lost before last");

    a_sop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1.sop) |=> ($countones(r_vbits) <= 1))
        else $error("start of pattern left stale channels");

    a_vbit_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_ok) |=> r_vbits[$past(r_s1_addr)])
        else $error("written channel not marked valid");
`endif

endmodule

// ===== design/tpp_pack.sv =====
// Per-cell packing: new channel state and the byte slots to send.
module tpp_pack import tpp_pkg::*; (
    input  t_cell  i_cell,
    input  logic   i_ok,
    input  t_entry i_base,
    output t_entry o_upd,
    output t_pack  o_pack
);

    logic [3:0] m;
    logic       hv;
    logic [7:0] hn;
    logic [7:0] lvl;
    logic [7:0] eff;
    logic [7:0] dat;
    logic [7:0] diff;
    logic [7:0] ib;
    logic       changed;

    always_comb begin
        m    = i_base.mask;
        hv   = i_base.hvld;
        hn   = i_base.hnote;
        lvl  = i_base.porta;
        eff  = 8'd0;
        dat  = 8'd0;
        diff = 8'd0;
        ib   = i_cell.instrument[7:0];

        if (i_cell.note_present) begin
            // a repeated note leaves the note bit alone
            if (!(hv && hn == i_cell.note)) begin
                m[MB_NOTE] = 1'b1;
                hn         = i_cell.note;
                hv         = 1'b1;
            end
        end else begin
            m[MB_NOTE] = 1'b0;
        end

        m[MB_INST] = (i_cell.instrument != INST_NONE);
        m[MB_VOL]  = (i_cell.volume != VOL_NONE);
        m[MB_EFF]  = (i_cell.effect_letter != 8'd0);

        if (i_cell.effect_letter == LET_P) begin
            if (i_cell.effect_param > lvl) begin
                eff  = EFF_UP;
                diff = i_cell.effect_param - lvl;
            end else if (i_cell.effect_param < lvl) begin
                eff  = EFF_DN;
                diff = lvl - i_cell.effect_param;
            end
            lvl = i_cell.effect_param;
            dat = DAT_BASE + (diff & NIB_MASK);
        end

        if (i_cell.second_letter == LET_V &&
            (i_cell.channel == 7'd1 || i_cell.channel == 7'd2)) begin
            m[MB_INST] = 1'b1;
            ib         = i_cell.second_param + 8'd1;
        end

        changed = (m != i_base.mask);

        o_upd = '{mask: m, hvld: hv, hnote: hn, porta: lvl};

        o_pack.bytes[SLOT_CH]   = changed ? ({1'b0, i_cell.channel} + CH_FLAG)
                                          : {1'b0, i_cell.channel};
        o_pack.bytes[SLOT_MASK] = {4'd0, m};
        o_pack.bytes[SLOT_NOTE] = hn;
        o_pack.bytes[SLOT_INST] = ib;
        o_pack.bytes[SLOT_VOL]  = {1'b0, i_cell.volume, 2'b00};
        o_pack.bytes[SLOT_EFF]  = eff;
        o_pack.bytes[SLOT_DAT]  = dat;
        o_pack.bytes[SLOT_EOR]  = 8'd0;

        o_pack.pend[SLOT_CH]   = i_ok;
        o_pack.pend[SLOT_MASK] = i_ok && changed;
        o_pack.pend[SLOT_NOTE] = i_ok && m[MB_NOTE];
        o_pack.pend[SLOT_INST] = i_ok && m[MB_INST];
        o_pack.pend[SLOT_VOL]  = i_ok && m[MB_VOL];
        o_pack.pend[SLOT_EFF]  = i_ok && m[MB_EFF];
        o_pack.pend[SLOT_DAT]  = i_ok && m[MB_EFF];
        o_pack.pend[SLOT_EOR]  = i_cell.eor;
    end

endmodule

// ===== design/tpp_ser.sv =====
// Output serializer: sends the pending byte slots of one cell in order.
module tpp_ser import tpp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_pack  i_pack,
    output logic   o_free,
    output logic   o_valid,
    input  logic   i_stall,
    output logic [7:0] o_out_byte,
    output logic   o_last
);

    logic [NSLOT-1:0][7:0] r_bytes;
    logic [NSLOT-1:0]      r_pend;
    logic [2:0]            sel;
    logic                  single;
    logic                  take;

    always_comb begin
        sel = 3'd0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = 3'(i);
            end
        end
    end

    assign single     = ((r_pend & (r_pend - 8'd1)) == 8'd0);
    assign o_valid    = |r_pend;
    assign o_last     = single;
    assign o_out_byte = r_bytes[sel];
    assign take       = o_valid && !i_stall;
    assign o_free     = !o_valid || (take && single);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_load) begin
            r_pend <= i_pack.pend;
        end else if (take) begin
            r_pend[sel] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_pack.bytes;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the tracker pattern packer core.
module tb
    import tpp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 4;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_GAP    = 12;
    localparam int CYCLE_LIMIT  = 100000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_start_of_pattern = 1'b0;
    logic [6:0]        i_channel = 7'd1;
    logic              i_note_present = 1'b0;
    logic [7:0]        i_note = 8'd0;
    logic signed [8:0] i_instrument = -9'sd1;
    logic signed [4:0] i_volume = -5'sd1;
    logic [7:0]        i_effect_letter = 8'd0;
    logic [7:0]        i_effect_param = 8'd0;
    logic [7:0]        i_second_letter = 8'd0;
    logic [7:0]        i_second_param = 8'd0;
    logic              i_end_of_row = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [7:0]        o_out_byte;
    logic              o_last;

    tracker_pattern_packer_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_start_of_pattern (i_start_of_pattern),
        .i_channel          (i_channel),
        .i_note_present     (i_note_present),
        .i_note             (i_note),
        .i_instrument       (i_instrument),
        .i_volume           (i_volume),
        .i_effect_letter    (i_effect_letter),
        .i_effect_param     (i_effect_param),
        .i_second_letter    (i_second_letter),
        .i_second_param     (i_second_param),
        .i_end_of_row       (i_end_of_row),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_byte         (o_out_byte),
        .o_last             (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Channel state as the packer should hold it
    logic [3:0] mask_q  [CHANNELS];
    logic       hvld_q  [CHANNELS];
    logic [7:0] hnote_q [CHANNELS];
    logic [7:0] porta_q [CHANNELS];

    t_cell cell_queue [$];
    t_word packed_bytes [$];
    t_cell shown_cell;
    t_cell next_cell;

    int send_idle = 21;
    int recv_idle = 83;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors    = 0;
    int cycles    = 0;

    function automatic void clear_channels();
        for (int i = 0; i < CHANNELS; i++) begin
            mask_q[i]  = 4'd0;
            hvld_q[i]  = 1'b0;
            hnote_q[i] = 8'd0;
            porta_q[i] = PORTA_RST;
        end
    endfunction

    function automatic void queue_cell(input t_cell c);
        cell_queue.insert(cell_queue.size(), c);
    endfunction

    // Work out the byte stream of one accepted cell and queue it
    function automatic void pack_cell(input t_cell c);
        logic [7:0] seq [$];
        int idx;
        logic [3:0] m;
        logic [7:0] ib, vb, eff, dat, lvl, diff;
        t_word w;
        if (c.sop) clear_channels();
        if (c.channel >= 7'd1 && c.channel <= CH_MAX) begin
            idx = int'(c.channel) - 1;
            m   = mask_q[idx];
            ib  = c.instrument[7:0];
            vb  = {1'b0, c.volume, 2'b00};
            eff = 8'd0;
            dat = 8'd0;
            if (c.note_present) begin
                if (!(hvld_q[idx] && hnote_q[idx] == c.note)) begin
                    m[MB_NOTE]   = 1'b1;
                    hnote_q[idx] = c.note;
                    hvld_q[idx]  = 1'b1;
                end
            end else begin
                m[MB_NOTE] = 1'b0;
            end
            m[MB_INST] = (c.instrument != INST_NONE);
            m[MB_VOL]  = (c.volume != VOL_NONE);
            if (c.effect_letter != 8'd0) begin
                if (c.effect_letter == LET_P) begin
                    lvl = porta_q[idx];
                    if (c.effect_param > lvl) begin
                        eff  = EFF_UP;
                        diff = c.effect_param - lvl;
                    end else if (c.effect_param < lvl) begin
                        eff  = EFF_DN;
                        diff = lvl - c.effect_param;
                    end else begin
                        diff = 8'd0;
                    end
                    porta_q[idx] = c.effect_param;
                    dat = DAT_BASE + (diff & NIB_MASK);
                end
                m[MB_EFF] = 1'b1;
            end else begin
                m[MB_EFF] = 1'b0;
            end
            // square duty on the first two channels overrides the instrument
            if (c.second_letter == LET_V && (c.channel == 7'd1 || c.channel == 7'd2)) begin
                m[MB_INST] = 1'b1;
                ib = c.second_param + 8'd1;
            end
            if (m != mask_q[idx]) begin
                seq.insert(seq.size(), CH_FLAG + {1'b0, c.channel});
                seq.insert(seq.size(), {4'd0, m});
                mask_q[idx] = m;
            end else begin
                seq.insert(seq.size(), {1'b0, c.channel});
            end
            if (m[MB_NOTE]) seq.insert(seq.size(), hnote_q[idx]);
            if (m[MB_INST]) seq.insert(seq.size(), ib);
            if (m[MB_VOL])  seq.insert(seq.size(), vb);
            if (m[MB_EFF]) begin
                seq.insert(seq.size(), eff);
                seq.insert(seq.size(), dat);
            end
        end
        if (c.eor) seq.insert(seq.size(), 8'd0);
        for (int k = 0; k < seq.size(); k++) begin
            w.data = seq[k];
            w.last = (k == seq.size() - 1);
            packed_bytes.insert(packed_bytes.size(), w);
        end
    endfunction

    function automatic t_cell rand_cell(input logic [6:0] ch, input logic eor);
        t_cell c;
        c.sop          = ($urandom_range(0, 99) < 3);
        c.channel      = ch;
        c.eor          = eor;
        c.note_present = 1'($urandom_range(0, 1));
        c.note         = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(60, 62))
                                                     : 8'($urandom_range(0, 255));
        c.instrument   = ($urandom_range(0, 99) < 25) ? INST_NONE : 9'($urandom_range(0, 511));
        c.volume       = ($urandom_range(0, 99) < 25) ? VOL_NONE : 5'($urandom_range(0, 31));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c.effect_letter = LET_P;
            4, 5, 6:    c.effect_letter = 8'd0;
            default:    c.effect_letter = 8'($urandom_range(0, 255));
        endcase
        c.effect_param  = 8'($urandom_range(0, 255));
        c.second_letter = ($urandom_range(0, 99) < 40) ? LET_V : 8'($urandom_range(0, 255));
        c.second_param  = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Mostly whole rows 1..n ending in end_of_row, with stray cells between
    task automatic add_rows(input int count);
        int n;
        int nch;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 85) begin
                nch = $urandom_range(1, 6);
                for (int ch = 1; ch <= nch; ch++)
                    queue_cell(rand_cell(7'(ch), ch == nch));
                n += nch;
            end else begin
                queue_cell(rand_cell(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
                n++;
            end
        end
    endtask

    task automatic wait_drained();
        while (cell_queue.size() != 0 || i_valid || packed_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic add_directed();
        t_cell c;
        // first cell of a pattern, full mask, portamento up from reset level
        c = '{sop: 1'b1, channel: 7'd1, note_present: 1'b1, note: 8'd60,
              instrument: 9'd1, volume: 5'd15, effect_letter: LET_P, effect_param: 8'd200,
              second_letter: 8'd0, second_param: 8'd0, eor: 1'b0};
        queue_cell(c);
        // repeated note with everything else dropped
        c.sop = 1'b0; c.instrument = INST_NONE; c.volume = VOL_NONE; c.effect_letter = 8'd0;
        queue_cell(c);
        // same cell again: mask unchanged, plain channel byte
        queue_cell(c);
        // square duty on channel 2 wraps the instrument to 0
        c = '{sop: 1'b0, channel: 7'd2, note_present: 1'b0, note: 8'hFF,
              instrument: INST_NONE, volume: VOL_NONE, effect_letter: 8'd0, effect_param: 8'd0,
              second_letter: LET_V, second_param: 8'hFF, eor: 1'b0};
        queue_cell(c);
        // portamento equal to level, then down by 128
        c = '{sop: 1'b0, channel: 7'd64, note_present: 1'b1, note: 8'd0,
              instrument: 9'd0, volume: 5'd0, effect_letter: LET_P, effect_param: 8'd128,
              second_letter: LET_V, second_param: 8'd7, eor: 1'b0};
        queue_cell(c);
        c.effect_param = 8'd0;
        queue_cell(c);
        c.effect_param = 8'd255;
        queue_cell(c);
        // other effect letter gives 0/0, square duty ignored on channel 3
        c = '{sop: 1'b0, channel: 7'd3, note_present: 1'b1, note: 8'd255,
              instrument: 9'd255, volume: 5'd15, effect_letter: LET_A, effect_param: 8'hAA,
              second_letter: LET_V, second_param: 8'd9, eor: 1'b1};
        queue_cell(c);
        c.effect_letter = 8'hFF;
        queue_cell(c);
        // out-of-range instrument and volume still count as present
        c.instrument = 9'h100; c.volume = 5'h10; c.effect_letter = 8'd1; c.eor = 1'b0;
        queue_cell(c);
        c.instrument = 9'h1FE; c.volume = 5'h1E;
        queue_cell(c);
        // out-of-range channels: row end only, or nothing at all
        c.channel = 7'd0; c.eor = 1'b1;
        queue_cell(c);
        c.channel = 7'd65; c.eor = 1'b0;
        queue_cell(c);
        c.channel = 7'd127; c.eor = 1'b1; c.sop = 1'b1;
        queue_cell(c);
        // longest output: channel 1, new mask, every field, row end
        c = '{sop: 1'b0, channel: 7'd1, note_present: 1'b1, note: 8'd255,
              instrument: 9'd5, volume: 5'd15, effect_letter: LET_P, effect_param: 8'd255,
              second_letter: LET_V, second_param: 8'd254, eor: 1'b1};
        queue_cell(c);
        // note absent but note bits set, level now reached
        c.note_present = 1'b0; c.second_letter = 8'd0;
        queue_cell(c);
        // pattern restart forgets the held note
        c.sop = 1'b1; c.note_present = 1'b1; c.note = 8'd60;
        queue_cell(c);
    endtask

    // Driver: offer queued cells, hold each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) pack_cell(shown_cell);
            if (!i_valid || !o_stall) begin
                if (cell_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    next_cell = cell_queue.pop_front();
                    shown_cell         <= next_cell;
                    i_valid            <= 1'b1;
                    i_start_of_pattern <= next_cell.sop;
                    i_channel          <= next_cell.channel;
                    i_note_present     <= next_cell.note_present;
                    i_note             <= next_cell.note;
                    i_instrument       <= next_cell.instrument;
                    i_volume           <= next_cell.volume;
                    i_effect_letter    <= next_cell.effect_letter;
                    i_effect_param     <= next_cell.effect_param;
                    i_second_letter    <= next_cell.second_letter;
                    i_second_param     <= next_cell.second_param;
                    i_end_of_row       <= next_cell.eor;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted word against the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (packed_bytes.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual byte %02h last %0b",
                             $time, o_out_byte, o_last);
                    errors++;
                end else begin
                    if (o_out_byte !== packed_bytes[0].data) begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, packed_bytes[0].data, o_out_byte);
                        errors++;
                    end
                    if (o_last !== packed_bytes[0].last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, packed_bytes[0].last, o_last);
                        errors++;
                    end
                    void'(packed_bytes.pop_front());
                end
            end
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        clear_channels();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 21;
        recv_idle = 83;
        add_directed();
        // pause the sender until the directed bytes are all out
        wait_drained();
        add_rows(30);
        wait_drained();

        send_idle = 83;
        recv_idle = 21;
        add_rows(30);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        add_rows(30);
        // long receiver hold-off while cells keep coming
        hold_reqs++;
        wait_drained();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tpp_pkg.sv
design/tpp_pack.sv
design/tpp_ser.sv
design/tracker_pattern_packer_core.sv
tb/tb.sv
